// File: rtl/core/iwlag_pkg.sv
// shared types, codes and constants of the int8 weight layout address generator
package iwlag_pkg;

    localparam int ROW_DEPTH = 4096;
    localparam int MAX_DIM   = 4096;

    typedef enum logic [2:0] {
        MODE_STRIPED = 3'd0,
        MODE_WAVE    = 3'd1,
        MODE_REPL    = 3'd2,
        MODE_ATTN    = 3'd3,
        MODE_BLOCK8  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_LAYOUT_MODE  = 3'd0,
        REG_BASE_ROW     = 3'd1,
        REG_ROW_STRIDE   = 3'd2,
        REG_REDUCTION    = 3'd3,
        REG_OUTPUT_COLS  = 3'd4,
        REG_HEMI_COUNT   = 3'd5,
        REG_MXM_COUNT    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] row_index;
        logic [11:0] column_index;
        logic [7:0]  weight_byte;
    } t_item;

    typedef struct packed {
        logic        hemisphere;
        logic [5:0]  slice_position;
        logic [11:0] row_address;
        logic [4:0]  byte_lane;
        logic [7:0]  weight_out;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // ceil(2^16 / d), exact quotient for 8-bit dividends and d up to 16
    function automatic logic [16:0] recip(input logic [4:0] d);
        logic [16:0] res;
        case (d)
            5'd1:    res = 17'd65536;
            5'd2:    res = 17'd32768;
            5'd3:    res = 17'd21846;
            5'd4:    res = 17'd16384;
            5'd5:    res = 17'd13108;
            5'd6:    res = 17'd10923;
            5'd7:    res = 17'd9363;
            5'd8:    res = 17'd8192;
            5'd9:    res = 17'd7282;
            5'd10:   res = 17'd6554;
            5'd11:   res = 17'd5958;
            5'd12:   res = 17'd5462;
            5'd13:   res = 17'd5042;
            5'd14:   res = 17'd4682;
            5'd15:   res = 17'd4370;
            5'd16:   res = 17'd4096;
            default: res = 17'd0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/iwlag_recip_div.sv
// two-stage small divider by reciprocal multiplication, quotient and remainder
module iwlag_recip_div
    import iwlag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_x,
    input  logic [4:0] i_d,
    output logic [7:0] o_q,
    output logic [3:0] o_r
);

    logic [7:0]  r_x;
    logic [4:0]  r_d;
    logic [7:0]  r_q;
    logic [7:0]  r_qo;
    logic [3:0]  r_ro;
    logic [24:0] prod;
    logic [12:0] qd;
    logic [12:0] diff;
    logic [7:0]  n_q;
    logic [3:0]  n_r;

    always_comb begin
        prod = {17'd0, i_x} * {8'd0, recip(i_d)};
        n_q  = prod[23:16];
        qd   = {5'd0, r_q} * {8'd0, r_d};
        diff = {5'd0, r_x} - qd;
        n_r  = diff[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_d  <= i_d;
            r_q  <= n_q;
            r_qo <= r_q;
            r_ro <= n_r;
        end
    end

    assign o_q = r_qo;
    assign o_r = r_ro;

endmodule

// File: rtl/core/int8_weight_layout_address_generator_unit.sv
// top level: weight position to sram placement, six-stage pipeline with apb config
// throughput: one transaction per cycle; a replicated item over two hemispheres
//   gives two results on consecutive cycles and holds busy high for one cycle
// reset: synchronous active low, clears pipeline valid bits and loads register defaults
// results are strobed for one cycle and cannot be stalled by the receiver
module int8_weight_layout_address_generator_unit
    import iwlag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = 19;
    localparam int ROW_W  = 28;

    typedef struct packed {
        logic [1:0]  status;
        logic        hem;
        logic [5:0]  slice;
        logic [6:0]  colblk;
        logic [6:0]  kblk;
        logic        scale8;
        logic [2:0]  off;
        logic [4:0]  lane;
        logic [7:0]  val;
    } t_s4;

    typedef struct packed {
        logic [1:0]        status;
        logic              hem;
        logic [5:0]        slice;
        logic [ADDR_W-1:0] addr;
        logic [4:0]        lane;
        logic [7:0]        val;
    } t_s5;

    logic [2:0]  r_mode;
    logic [11:0] r_base;
    logic [7:0]  r_stride;
    logic [12:0] r_k_dim;
    logic [12:0] r_n_dim;
    logic [1:0]  r_hc;
    logic [3:0]  r_mxm;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_item       r_it1, r_it2, r_it3;
    t_s4         r_s4, n_s4;
    t_s5         r_s5, n_s5;
    t_result     r_res, n_res;
    logic        r_dual, n_dual;
    logic        r_second;

    logic        stall;
    logic        adv;
    logic        cfg_wr;
    logic [7:0]  qa, qb;
    logic [3:0]  ra, rb;
    logic [5:0]  hm_prod;
    logic        cfg_bad;
    logic        misalign;
    logic [14:0] cb_prod;
    logic [15:0] blk_sum;
    logic [ADDR_W-1:0] addr_sh;
    logic [ROW_W-1:0]  row_full;
    logic [1:0]  st6;

    assign stall  = r_v6 & r_dual & ~r_second;
    assign adv    = ~stall;
    assign busy   = stall;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_STRIPED;
            r_base   <= 12'd0;
            r_stride <= 8'd1;
            r_k_dim  <= 13'd32;
            r_n_dim  <= 13'd128;
            r_hc     <= 2'd2;
            r_mxm    <= 4'd1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_LAYOUT_MODE: r_mode   <= pwdata[2:0];
                REG_BASE_ROW:    r_base   <= pwdata[11:0];
                REG_ROW_STRIDE:  r_stride <= pwdata[7:0];
                REG_REDUCTION:   r_k_dim  <= pwdata[12:0];
                REG_OUTPUT_COLS: r_n_dim  <= pwdata[12:0];
                REG_HEMI_COUNT:  r_hc     <= pwdata[1:0];
                REG_MXM_COUNT:   r_mxm    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LAYOUT_MODE: prdata = {29'd0, r_mode};
            REG_BASE_ROW:    prdata = {20'd0, r_base};
            REG_ROW_STRIDE:  prdata = {24'd0, r_stride};
            REG_REDUCTION:   prdata = {19'd0, r_k_dim};
            REG_OUTPUT_COLS: prdata = {19'd0, r_n_dim};
            REG_HEMI_COUNT:  prdata = {30'd0, r_hc};
            REG_MXM_COUNT:   prdata = {28'd0, r_mxm};
            default:         prdata = 32'd0;
        endcase
    end

    // column group split for block8 and n-dimension alignment check
    assign hm_prod = {4'd0, r_hc} * {2'd0, r_mxm};

    iwlag_recip_div u_div_col (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   ({1'b0, r_it1.column_index[11:5]}),
        .i_d   ({1'b0, r_mxm}),
        .o_q   (qa),
        .o_r   (ra)
    );

    iwlag_recip_div u_div_dim (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_n_dim[12:5]),
        .i_d   (hm_prod[4:0]),
        .o_q   (qb),
        .o_r   (rb)
    );

    // stage 3 to 4: checks and layout decode
    always_comb begin
        logic [11:0] k;
        logic [11:0] n;
        k = r_it3.row_index;
        n = r_it3.column_index;

        cfg_bad = (r_mode > MODE_BLOCK8) || (r_stride == 8'd0) ||
                  (r_hc == 2'd0) || (r_hc == 2'd3) ||
                  (r_k_dim > 13'(MAX_DIM)) || (r_n_dim > 13'(MAX_DIM)) ||
                  ((r_mode == MODE_BLOCK8) && ((r_mxm == 4'd0) || (r_mxm > 4'd8)));

        case (r_mode)
            MODE_REPL:   misalign = (r_k_dim[4:0] != 5'd0) || (r_n_dim[4:0] != 5'd0);
            MODE_ATTN:   misalign = (r_k_dim[4:0] != 5'd0) || (r_n_dim[5:0] != 6'd0);
            MODE_BLOCK8: misalign = (r_k_dim[4:0] != 5'd0) || (r_n_dim[4:0] != 5'd0) ||
                                    (rb != 4'd0);
            default:     misalign = 1'b0;
        endcase

        if (cfg_bad || misalign) begin
            n_s4.status = ST_MISALIGN;
        end else if (({1'b0, k} >= r_k_dim) || ({1'b0, n} >= r_n_dim)) begin
            n_s4.status = ST_RANGE;
        end else begin
            n_s4.status = ST_OK;
        end

        n_s4.slice  = {3'd0, n[2:0]};
        n_s4.kblk   = k[11:5];
        n_s4.lane   = k[4:0];
        n_s4.val    = r_it3.weight_byte;
        n_s4.scale8 = 1'b0;
        n_s4.off    = {1'b0, ~n[4:3]};

        case (r_mode)
            MODE_STRIPED: begin
                n_s4.hem    = n[5];
                n_s4.colblk = {1'b0, n[11:6]};
            end
            MODE_WAVE, MODE_ATTN: begin
                n_s4.hem    = n[6];
                n_s4.colblk = {2'b00, n[11:7]};
                n_s4.scale8 = 1'b1;
                n_s4.off    = {n[5], ~n[4:3]};
            end
            MODE_REPL: begin
                n_s4.hem    = 1'b0;
                n_s4.colblk = n[11:5];
            end
            default: begin
                n_s4.hem    = (r_hc == 2'd2) ? qa[0] : 1'b0;
                n_s4.colblk = (r_hc == 2'd2) ? qa[7:1] : qa[6:0];
                n_s4.slice  = {ra[2:0], n[2:0]};
            end
        endcase
    end

    // stage 4 to 5: logical address
    always_comb begin
        cb_prod = {8'd0, r_s4.colblk} * {7'd0, r_k_dim[12:5]};
        blk_sum = {1'b0, cb_prod} + {9'd0, r_s4.kblk};
        addr_sh = r_s4.scale8 ? {blk_sum, 3'b000} : {1'b0, blk_sum, 2'b00};
        n_s5.addr   = addr_sh + {{(ADDR_W-3){1'b0}}, r_s4.off};
        n_s5.status = r_s4.status;
        n_s5.hem    = r_s4.hem;
        n_s5.slice  = r_s4.slice;
        n_s5.lane   = r_s4.lane;
        n_s5.val    = r_s4.val;
    end

    // stage 5 to 6: physical row and final status
    always_comb begin
        row_full = {{(ROW_W-12){1'b0}}, r_base} +
                   ({{(ROW_W-ADDR_W){1'b0}}, r_s5.addr} * {{(ROW_W-8){1'b0}}, r_stride});
        st6 = r_s5.status;
        if ((st6 == ST_OK) &&
            (({1'b0, r_s5.hem} >= r_hc) || (row_full >= ROW_W'(ROW_DEPTH)))) begin
            st6 = ST_RANGE;
        end
        if (st6 != ST_OK) begin
            n_res  = '0;
            n_res.status = st6;
            n_res.last   = 1'b1;
            n_dual = 1'b0;
        end else begin
            n_dual = (r_mode == MODE_REPL) && (r_hc == 2'd2);
            n_res.hemisphere     = r_s5.hem;
            n_res.slice_position = r_s5.slice;
            n_res.row_address    = row_full[11:0];
            n_res.byte_lane      = r_s5.lane;
            n_res.weight_out     = r_s5.val;
            n_res.status         = ST_OK;
            n_res.last           = ~n_dual;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_second <= stall;
            if (adv) begin
                r_v1 <= start;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it1  <= i_item;
            r_it2  <= r_it1;
            r_it3  <= r_it2;
            r_s4   <= n_s4;
            r_s5   <= n_s5;
            r_res  <= n_res;
            r_dual <= n_dual;
        end
    end

    // second replicated transaction targets hemisphere one and closes the item
    always_comb begin
        o_res            = r_res;
        o_res.hemisphere = r_res.hemisphere | r_second;
        o_res.last       = r_res.last | r_second;
    end

    assign o_res_valid = r_v6;

endmodule

// File: rtl/core/iwlag_checker.sv
// port-level assertion checker for the address generator, bound to the top level
module iwlag_checker
    import iwlag_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_res_valid,
    input t_result     o_res
);

    // busy only while the first of two replicated results is shown
    a_busy_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_res_valid && !o_res.last && !o_res.hemisphere))
        else $error("busy without pending replicated transaction");

    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_res_valid && o_res.last && o_res.hemisphere && !busy))
        else $error("second replicated transaction missing");

    a_second_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=>
            (o_res.row_address == $past(o_res.row_address) &&
             o_res.byte_lane == $past(o_res.byte_lane) &&
             o_res.weight_out == $past(o_res.weight_out)))
        else $error("replicated transactions differ");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |->
            (o_res.last && o_res.row_address == 12'd0 &&
             o_res.weight_out == 8'd0 && !o_res.hemisphere))
        else $error("error transaction carries payload");

endmodule

bind int8_weight_layout_address_generator_unit iwlag_checker u_iwlag_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench for the weight layout address generator: directed table, random phases, predictor
module tb;
    import iwlag_pkg::*;

    typedef struct {
        logic        is_cfg;
        t_reg_idx    cfg_reg;
        logic [31:0] cfg_val;
        t_item       item;
        logic        fixed;
        t_result     res;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_res_valid;
    t_result     o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [2:0]  cfg_mode;
    logic [11:0] cfg_base;
    logic [7:0]  cfg_stride;
    logic [12:0] cfg_k;
    logic [12:0] cfg_n;
    logic [1:0]  cfg_hc;
    logic [3:0]  cfg_mxm;

    t_result     placement_q[$];
    t_step       steps[$];
    int          err_count = 0;
    logic        fixed_pending = 1'b0;
    t_result     fixed_res;

    always #5 i_clk = ~i_clk;

    int8_weight_layout_address_generator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 50) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    task automatic compare_placement(input t_result got, input t_result want);
        if (got.hemisphere !== want.hemisphere)
            report_mismatch($sformatf("hemisphere %0h, want %0h", got.hemisphere,
                                      want.hemisphere));
        if (got.slice_position !== want.slice_position)
            report_mismatch($sformatf("slice_position %0d, want %0d", got.slice_position,
                                      want.slice_position));
        if (got.row_address !== want.row_address)
            report_mismatch($sformatf("row_address %0d, want %0d", got.row_address,
                                      want.row_address));
        if (got.byte_lane !== want.byte_lane)
            report_mismatch($sformatf("byte_lane %0d, want %0d", got.byte_lane,
                                      want.byte_lane));
        if (got.weight_out !== want.weight_out)
            report_mismatch($sformatf("weight_out %0h, want %0h", got.weight_out,
                                      want.weight_out));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0h, want %0h", got.last, want.last));
    endtask

    function automatic t_result fault_result(input t_status st);
        return t_result'{1'b0, 6'd0, 12'd0, 5'd0, 8'd0, st, 1'b1};
    endfunction

    function automatic void predict_placement(input t_item it);
        int unsigned k, n, kk, nn, hc, mxm, kb, pulse, cph, cpw, hem, slice, addr, row, h;
        t_status st;
        t_result r;
        k = it.row_index;
        n = it.column_index;
        kk = cfg_k;
        nn = cfg_n;
        hc = cfg_hc;
        mxm = cfg_mxm;
        kb = kk / 32;
        pulse = 3 - (n % 32) / 8;
        slice = n % 8;
        hem = 0;
        addr = 0;
        row = 0;
        cph = 0;
        cpw = 0;
        st = ST_OK;
        if (cfg_mode > MODE_BLOCK8 || cfg_stride == 0 || hc == 0 || hc > 2 ||
            kk > MAX_DIM || nn > MAX_DIM ||
            (cfg_mode == MODE_BLOCK8 && (mxm == 0 || mxm > 8))) begin
            st = ST_MISALIGN;
        end else begin
            if (cfg_mode == MODE_BLOCK8) begin
                cph = mxm * 32;
                cpw = hc * cph;
            end
            if (cfg_mode == MODE_REPL && (kk % 32 != 0 || nn % 32 != 0))
                st = ST_MISALIGN;
            else if (cfg_mode == MODE_ATTN && (kk % 32 != 0 || nn % 64 != 0))
                st = ST_MISALIGN;
            else if (cfg_mode == MODE_BLOCK8 && (kk % 32 != 0 || nn % cpw != 0))
                st = ST_MISALIGN;
        end
        if (st == ST_OK && (k >= kk || n >= nn)) st = ST_RANGE;
        if (st == ST_OK) begin
            case (cfg_mode)
                MODE_STRIPED: begin
                    hem = (n / 32) % 2;
                    addr = ((n / 64) * kb + k / 32) * 4 + pulse;
                end
                MODE_WAVE, MODE_ATTN: begin
                    hem = (n / 64) % 2;
                    addr = ((n / 128) * kb + k / 32) * 8 + ((n % 64) / 32) * 4 + pulse;
                end
                MODE_REPL: begin
                    hem = 0;
                    addr = ((n / 32) * kb + k / 32) * 4 + pulse;
                end
                default: begin
                    hem = (n / cph) % hc;
                    slice = ((n % cph) / 32) * 8 + n % 8;
                    addr = ((n / cpw) * kb + k / 32) * 4 + pulse;
                end
            endcase
            row = cfg_base + addr * cfg_stride;
            if (hem >= hc || row >= ROW_DEPTH) st = ST_RANGE;
        end
        if (st != ST_OK) begin
            placement_q = {placement_q, fault_result(st)};
        end else begin
            r.slice_position = 6'(slice);
            r.row_address = 12'(row);
            r.byte_lane = 5'(k % 32);
            r.weight_out = it.weight_byte;
            r.status = ST_OK;
            if (cfg_mode == MODE_REPL) begin
                for (h = 0; h < hc; h++) begin
                    r.hemisphere = 1'(h);
                    r.last = (h + 1 == hc);
                    placement_q = {placement_q, r};
                end
            end else begin
                r.hemisphere = 1'(hem);
                r.last = 1'b1;
                placement_q = {placement_q, r};
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (placement_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                    compare_placement(o_res, placement_q.pop_front());
            end
            if (start && !busy) begin
                if (fixed_pending) begin
                    placement_q = {placement_q, fixed_res};
                    fixed_pending = 1'b0;
                end else begin
                    predict_placement(i_item);
                end
            end
        end
    end

    task automatic read_check(input t_reg_idx idx);
        logic [31:0] want;
        case (idx)
            REG_LAYOUT_MODE: want = {29'd0, cfg_mode};
            REG_BASE_ROW:    want = {20'd0, cfg_base};
            REG_ROW_STRIDE:  want = {24'd0, cfg_stride};
            REG_REDUCTION:   want = {19'd0, cfg_k};
            REG_OUTPUT_COLS: want = {19'd0, cfg_n};
            REG_HEMI_COUNT:  want = {30'd0, cfg_hc};
            REG_MXM_COUNT:   want = {28'd0, cfg_mxm};
            default:         want = '0;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %s reads %0h, want %0h", idx.name(),
                                      prdata, want));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_LAYOUT_MODE: cfg_mode = val[2:0];
            REG_BASE_ROW:    cfg_base = val[11:0];
            REG_ROW_STRIDE:  cfg_stride = val[7:0];
            REG_REDUCTION:   cfg_k = val[12:0];
            REG_OUTPUT_COLS: cfg_n = val[12:0];
            REG_HEMI_COUNT:  cfg_hc = val[1:0];
            REG_MXM_COUNT:   cfg_mxm = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        read_check(idx);
    endtask

    task automatic drain_block();
        start <= 1'b0;
        while (placement_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic send_item(input t_item it, input int gap, input bit hold);
        if (hold && gap == 0) gap = 1;
        if (gap > 0) begin
            start <= 1'b0;
            if (hold) begin
                while (placement_q.size() != 0) @(negedge i_clk);
            end
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic randomize_config();
        logic [2:0]  mode;
        logic [1:0]  hc;
        logic [3:0]  mxm;
        logic [12:0] kk;
        logic [12:0] nn;
        logic [11:0] base;
        logic [7:0]  stride;
        int unsigned cpw;
        mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0)
            hc = $urandom_range(0, 1) ? 2'd3 : 2'd0;
        else
            hc = ($urandom_range(0, 3) == 0) ? 2'd1 : 2'd2;
        if ($urandom_range(0, 9) == 0)
            mxm = $urandom_range(0, 1) ? 4'($urandom_range(9, 15)) : 4'd0;
        else
            mxm = 4'($urandom_range(1, 8));
        case ($urandom_range(0, 19))
            0:       kk = 13'($urandom_range(4097, 8191));
            1:       kk = 13'd4096;
            2, 3:    kk = 13'($urandom_range(1, 4096));
            default: kk = 13'(32 * $urandom_range(1, 8));
        endcase
        if (mode == MODE_BLOCK8 && (hc == 1 || hc == 2) && mxm >= 1 && mxm <= 8)
            cpw = hc * mxm * 32;
        else
            cpw = 64;
        case ($urandom_range(0, 19))
            0:       nn = 13'($urandom_range(4097, 8191));
            1:       nn = 13'd4096;
            2, 3:    nn = 13'($urandom_range(1, 4096));
            default: nn = 13'(cpw * $urandom_range(1, (cpw > 256) ? 2 : 4));
        endcase
        base = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
            0:       stride = 8'd0;
            1, 2:    stride = 8'($urandom_range(1, 255));
            3:       stride = 8'd255;
            default: stride = 8'($urandom_range(1, 4));
        endcase
        write_register(REG_LAYOUT_MODE, {29'd0, mode});
        write_register(REG_BASE_ROW, {20'd0, base});
        write_register(REG_ROW_STRIDE, {24'd0, stride});
        write_register(REG_REDUCTION, {19'd0, kk});
        write_register(REG_OUTPUT_COLS, {19'd0, nn});
        write_register(REG_HEMI_COUNT, {30'd0, hc});
        write_register(REG_MXM_COUNT, {28'd0, mxm});
    endtask

    function automatic void add_cfg(input t_reg_idx idx, input logic [31:0] val);
        t_step s;
        s.is_cfg = 1'b1;
        s.cfg_reg = idx;
        s.cfg_val = val;
        s.item = '0;
        s.fixed = 1'b0;
        s.res = '0;
        steps = {steps, s};
    endfunction

    function automatic void add_item(input logic [11:0] k, input logic [11:0] n,
                                     input logic [7:0] v, input logic fixed,
                                     input t_result res);
        t_step s;
        s.is_cfg = 1'b0;
        s.cfg_reg = REG_LAYOUT_MODE;
        s.cfg_val = '0;
        s.item = t_item'{k, n, v};
        s.fixed = fixed;
        s.res = res;
        steps = {steps, s};
    endfunction

    initial begin
        int          random_items;
        int          gap_mode;
        int          cnt;
        int unsigned kmax;
        int unsigned nmax;
        t_item       it;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_mode = MODE_STRIPED;
        cfg_base = 12'd0;
        cfg_stride = 8'd1;
        cfg_k = 13'd32;
        cfg_n = 13'd128;
        cfg_hc = 2'd2;
        cfg_mxm = 4'd1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int r = 0; r <= REG_MXM_COUNT; r++) begin
            read_check(t_reg_idx'(r));
        end

        // reset configuration: striped, K 32, N 128, two hemispheres
        add_item(12'd0, 12'd0, 8'h00, 1'b1,
                 t_result'{1'b0, 6'd0, 12'd3, 5'd0, 8'h00, ST_OK, 1'b1});
        add_item(12'd31, 12'd127, 8'hFF, 1'b1,
                 t_result'{1'b1, 6'd7, 12'd4, 5'd31, 8'hFF, ST_OK, 1'b1});
        add_item(12'd32, 12'd0, 8'h11, 1'b1, fault_result(ST_RANGE));
        add_item(12'd0, 12'd128, 8'h22, 1'b1, fault_result(ST_RANGE));
        add_item(12'd4095, 12'd4095, 8'hAA, 1'b1, fault_result(ST_RANGE));
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_WAVE));
        add_item(12'd5, 12'd100, 8'h5A, 1'b0, '0);
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_REPL));
        add_item(12'd17, 12'd77, 8'hC3, 1'b0, '0);
        add_cfg(REG_HEMI_COUNT, 32'd1);
        add_item(12'd31, 12'd127, 8'h0F, 1'b0, '0);
        add_cfg(REG_HEMI_COUNT, 32'd3);
        add_item(12'd0, 12'd0, 8'h01, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_HEMI_COUNT, 32'd0);
        add_item(12'd0, 12'd0, 8'h02, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_HEMI_COUNT, 32'd2);
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_ATTN));
        add_cfg(REG_OUTPUT_COLS, 32'd96);
        add_item(12'd1, 12'd1, 8'h03, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_OUTPUT_COLS, 32'd128);
        add_item(12'd9, 12'd70, 8'h99, 1'b0, '0);
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_BLOCK8));
        add_cfg(REG_MXM_COUNT, 32'd2);
        add_item(12'd20, 12'd100, 8'h44, 1'b0, '0);
        add_cfg(REG_MXM_COUNT, 32'd9);
        add_item(12'd0, 12'd0, 8'h04, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_MXM_COUNT, 32'd8);
        add_item(12'd0, 12'd0, 8'h05, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_OUTPUT_COLS, 32'd512);
        add_cfg(REG_REDUCTION, 32'd64);
        add_item(12'd63, 12'd511, 8'hFE, 1'b0, '0);
        add_cfg(REG_LAYOUT_MODE, 32'd5);
        add_item(12'd0, 12'd0, 8'h06, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_STRIPED));
        add_cfg(REG_ROW_STRIDE, 32'd0);
        add_item(12'd0, 12'd0, 8'h07, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_ROW_STRIDE, 32'd255);
        add_cfg(REG_BASE_ROW, 32'd4095);
        add_item(12'd0, 12'd0, 8'h08, 1'b1, fault_result(ST_RANGE));
        add_cfg(REG_ROW_STRIDE, 32'd1);
        add_cfg(REG_BASE_ROW, 32'd0);
        add_cfg(REG_REDUCTION, 32'd4097);
        add_item(12'd0, 12'd0, 8'h09, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_REDUCTION, 32'd8191);
        add_cfg(REG_OUTPUT_COLS, 32'd8191);
        add_item(12'd0, 12'd0, 8'h0A, 1'b1, fault_result(ST_MISALIGN));
        add_cfg(REG_REDUCTION, 32'd33);
        add_cfg(REG_OUTPUT_COLS, 32'd65);
        add_item(12'd32, 12'd64, 8'h80, 1'b0, '0);
        // hemisphere 1 with a single hemisphere target
        add_cfg(REG_REDUCTION, 32'd32);
        add_cfg(REG_OUTPUT_COLS, 32'd128);
        add_cfg(REG_HEMI_COUNT, 32'd1);
        add_item(12'd0, 12'd32, 8'h12, 1'b1, fault_result(ST_RANGE));
        add_cfg(REG_HEMI_COUNT, 32'd2);
        add_cfg(REG_MXM_COUNT, 32'd0);
        add_cfg(REG_LAYOUT_MODE, 32'(MODE_BLOCK8));
        add_item(12'd0, 12'd0, 8'h34, 1'b1, fault_result(ST_MISALIGN));

        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                drain_block();
                write_register(steps[i].cfg_reg, steps[i].cfg_val);
            end else begin
                fixed_pending = steps[i].fixed;
                fixed_res = steps[i].res;
                send_item(steps[i].item, $urandom_range(0, 7), i == 4);
            end
        end

        random_items = 0;
        while (random_items < 1450) begin
            drain_block();
            randomize_config();
            gap_mode = $urandom_range(0, 3);
            cnt = $urandom_range(20, 80);
            kmax = (cfg_k == 0) ? 0 : ((cfg_k > 4096) ? 4095 : cfg_k - 1);
            nmax = (cfg_n == 0) ? 0 : ((cfg_n > 4096) ? 4095 : cfg_n - 1);
            repeat (cnt) begin
                if ($urandom_range(0, 6) == 0) begin
                    it.row_index = 12'($urandom);
                    it.column_index = 12'($urandom);
                end else begin
                    it.row_index = 12'($urandom_range(0, kmax));
                    it.column_index = 12'($urandom_range(0, nmax));
                end
                it.weight_byte = 8'($urandom);
                send_item(it, (gap_mode == 0) ? 0 : $urandom_range(0, 7),
                          $urandom_range(0, 59) == 0);
                random_items++;
            end
        end

        drain_block();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: int8_weight_layout_address_generator_unit.f
rtl/core/iwlag_pkg.sv
rtl/core/iwlag_recip_div.sv
rtl/core/int8_weight_layout_address_generator_unit.sv
rtl/core/iwlag_checker.sv
sim/tb.sv
